/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps

package skf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 17;
  localparam int unsigned OutW  = 88;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned CntW  = $clog2(DivSteps + 1);

  localparam logic [GainW-1:0] OneQ16  = 17'h10000;
  localparam logic [DataW-1:0] VarMax  = 32'hFFFF_FFFF;

  localparam logic [DataW-1:0] ProcessNoiseRst     = 32'd655;
  localparam logic [DataW-1:0] MeasurementNoiseRst = 32'd655;
  localparam logic [DataW-1:0] InitialVarianceRst  = 32'd6554;

  typedef enum logic [1:0] {
    CfgProcessNoise     = 2'd0,
    CfgMeasurementNoise = 2'd1,
    CfgInitialVariance  = 2'd2
  } cfg_idx_e;

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataW] ? VarMax : s[DataW-1:0];
  endfunction

endpackage

/* rtl/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// Scalar Kalman filter, Q16.16 fixed point, Joseph-form variance update.
// Input stream: tuser is the command (0 = measurement, 1 = restart), tdata
// the signed Q16.16 sample. Output stream: one request per input request
// with estimate, posterior variance and Q1.16 gain packed in tdata.
// Configuration: write channel with a 2-bit register index (0 = process
// noise Q, 1 = measurement noise R, 2 = initial variance); other indices
// are ignored. Write only while the filter is idle.
// Processing: a measurement passes through the accept step, one add, 17
// steps of the restoring gain divider, one setup step, five passes through
// the single shared 32x32 multiplier, one sum and the output step. A
// restart goes from the accept step straight to the output step. The
// result appears in the same cycle that input is ready again.
// The input is not ready while a request is in work. A finished result
// waits in the output register; if the receiver stalls, the filter holds
// in its final step until the register drains, so no result is lost.
// Reset clears the prior estimate to 0, loads the prior variance and
// registers with their defaults and drops any pending result.
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // [31:0] sample_value
  input  logic             s_axis_tuser,  // [0] cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutW-1:0]  m_axis_tdata,  // [31:0] estimate, [63:32] posterior_variance,
                                          // [80:64] gain, [87:81] zero
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [DataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEN, ST_DIV, ST_FIX, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_FIN
  } state_e;

  state_e                   state_q;
  logic                     cmd_q;
  logic signed [DataW-1:0]  z_q, x_q, est_q;
  logic [DataW-1:0]         p_q, qn_q, rn_q, iv_q;
  logic [DataW:0]           den_q;
  logic [DataW+1:0]         rem_q;
  logic [GainW-1:0]         quo_q, k_q;
  logic [CntW-1:0]          cnt_q;
  logic [DataW-1:0]         mag_q, t1_q, post_q;
  logic                     neg_q;
  logic [2*DataW-1:0]       prod_q;
  logic                     m_valid_q;
  logic [OutW-1:0]          m_data_q;

  logic [DataW:0]           diff, diff_neg;
  logic [DataW-1:0]         mag;
  logic [GainW-1:0]         j;
  logic [DataW-1:0]         mul_a, mul_b;
  logic [2*DataW-1:0]       mul_p;
  logic                     rem_ge;
  logic [DataW+1:0]         rem_sub;
  logic [48:0]              rnd;
  logic [DataW:0]           qmag;
  logic [DataW+1:0]         est_w;
  logic signed [DataW-1:0]  est_c;
  logic [DataW-1:0]         t2;
  logic                     out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign diff     = {z_q[DataW-1], z_q} - {x_q[DataW-1], x_q};
  assign diff_neg = '0 - diff;
  assign mag      = diff[DataW] ? diff_neg[DataW-1:0] : diff[DataW-1:0];
  assign j        = OneQ16 - k_q;

  always_comb begin
    case (state_q)
      ST_M1: begin
        mul_a = {16'd0, k_q[15:0]};
        mul_b = mag_q;
      end
      ST_M2: begin
        mul_a = {16'd0, j[15:0]};
        mul_b = {16'd0, j[15:0]};
      end
      ST_M3: begin
        mul_a = prod_q[DataW-1:0];
        mul_b = p_q;
      end
      ST_M4: begin
        mul_a = {16'd0, k_q[15:0]};
        mul_b = {16'd0, k_q[15:0]};
      end
      ST_M5: begin
        mul_a = prod_q[DataW-1:0];
        mul_b = rn_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign rem_ge  = rem_q >= {1'b0, den_q};
  assign rem_sub = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  assign rnd   = prod_q[48:0] + 49'd65535;
  assign qmag  = k_q[16] ? {1'b0, mag_q} : (neg_q ? rnd[48:16] : prod_q[48:16]);
  assign est_w = neg_q ? ({{2{x_q[DataW-1]}}, x_q} - {1'b0, qmag})
                       : ({{2{x_q[DataW-1]}}, x_q} + {1'b0, qmag});
  always_comb begin
    if (est_w[33:31] == 3'b000 || est_w[33:31] == 3'b111) begin
      est_c = est_w[DataW-1:0];
    end else if (est_w[33]) begin
      est_c = 32'sh8000_0000;
    end else begin
      est_c = 32'sh7FFF_FFFF;
    end
  end

  assign t2 = k_q[16] ? rn_q : prod_q[2*DataW-1:DataW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q <= ProcessNoiseRst;
      rn_q <= MeasurementNoiseRst;
      iv_q <= InitialVarianceRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgProcessNoise:     qn_q <= cfg_data_i;
        CfgMeasurementNoise: rn_q <= cfg_data_i;
        CfgInitialVariance:  iv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      x_q       <= '0;
      p_q       <= InitialVarianceRst;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (m_axis_tready && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= s_axis_tuser;
            z_q     <= s_axis_tdata;
            state_q <= s_axis_tuser ? ST_FIN : ST_DEN;
          end
        end
        ST_DEN: begin
          den_q   <= {1'b0, p_q} + {1'b0, rn_q};
          rem_q   <= {2'b00, p_q};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= {rem_sub[DataW:0], 1'b0};
          quo_q <= {quo_q[GainW-2:0], rem_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          k_q     <= (den_q == '0) ? '0 : quo_q;
          mag_q   <= mag;
          neg_q   <= diff[DataW];
          state_q <= ST_M1;
        end
        ST_M1: begin
          prod_q  <= mul_p;
          state_q <= ST_M2;
        end
        ST_M2: begin
          est_q   <= est_c;
          prod_q  <= mul_p;
          state_q <= ST_M3;
        end
        ST_M3: begin
          prod_q  <= mul_p;
          state_q <= ST_M4;
        end
        ST_M4: begin
          t1_q    <= j[16] ? p_q : prod_q[2*DataW-1:DataW];
          prod_q  <= mul_p;
          state_q <= ST_M5;
        end
        ST_M5: begin
          prod_q  <= mul_p;
          state_q <= ST_M6;
        end
        ST_M6: begin
          post_q  <= sat_add(t1_q, t2);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
            if (cmd_q) begin
              x_q      <= z_q;
              p_q      <= iv_q;
              m_data_q <= {7'd0, 17'd0, iv_q, z_q};
            end else begin
              x_q      <= est_q;
              p_q      <= sat_add(post_q, qn_q);
              m_data_q <= {7'd0, k_q, post_q, est_q};
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[80:64] <= OneQ16))
    else $error("gain above unity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted request did not start");

  a_zero_den_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M1 && den_q == '0) |-> (k_q == '0))
    else $error("nonzero gain with zero denominator");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CntW'(DivSteps)))
    else $error("divider step count overrun");

endmodule

/* sim/scalar_kalman_filter_tb.sv */
`timescale 1ns / 1ps

module scalar_kalman_filter_tb;
  import skf_pkg::*;

  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdRestart = 1'b1;
  localparam logic [1:0] CfgNoSuchReg = 2'd3;
  localparam longint EstMax = 64'sd2147483647;
  localparam longint EstMin = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] estimate;
    logic [31:0] variance;
    logic [16:0] gain;
  } filt_out_t;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        cmd;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        typed;
    logic [31:0] estimate;
    logic [31:0] variance;
    logic [16:0] gain;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  scalar_kalman_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [31:0] reg_q  = ProcessNoiseRst;
  logic [31:0] reg_r  = MeasurementNoiseRst;
  logic [31:0] reg_p0 = InitialVarianceRst;
  logic [31:0] filt_est = '0;
  logic [31:0] filt_var = InitialVarianceRst;

  filt_out_t pending_results [$];
  filt_out_t typed_result;
  logic      use_typed = 1'b0;
  int unsigned errors = 0;
  int unsigned burst_left = 0;

  row_t plan [27];

  function automatic logic [31:0] clip_var(input logic [63:0] s);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [63:0] scaled_square(input logic [16:0] w, input logic [31:0] v);
    logic [63:0] sq;
    if (w >= OneQ16) return {32'd0, v};
    sq = 64'(w) * 64'(w);
    return (sq * 64'(v)) >> 32;
  endfunction

  function automatic filt_out_t filter_step(input logic cmd, input logic [31:0] z);
    filt_out_t o;
    logic [32:0] den;
    logic [63:0] k, adj, post;
    longint diff, est;
    if (cmd == CmdRestart) begin
      filt_est = z;
      filt_var = reg_p0;
      o.estimate = z;
      o.variance = reg_p0;
      o.gain = '0;
      return o;
    end
    den = {1'b0, filt_var} + {1'b0, reg_r};
    k = (den == '0) ? 64'd0 : ({32'd0, filt_var} << 16) / {31'd0, den};
    if (k > 64'd65536) k = 64'd65536;
    diff = longint'($signed(z)) - longint'($signed(filt_est));
    if (diff >= 0) begin
      adj = (k * unsigned'(diff)) >> 16;
      est = longint'($signed(filt_est)) + longint'(adj);
    end else begin
      adj = (k * unsigned'(-diff) + 64'd65535) >> 16;
      est = longint'($signed(filt_est)) - longint'(adj);
    end
    if (est > EstMax) est = EstMax;
    if (est < EstMin) est = EstMin;
    post = scaled_square(17'(64'd65536 - k), filt_var) + scaled_square(k[16:0], reg_r);
    o.estimate = est[31:0];
    o.variance = clip_var(post);
    o.gain = k[16:0];
    filt_est = est[31:0];
    filt_var = clip_var(64'(o.variance) + 64'(reg_q));
    return o;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h, want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor
    filt_out_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.estimate = m_axis_tdata[31:0];
        got.variance = m_axis_tdata[63:32];
        got.gain     = m_axis_tdata[80:64];
        if (pending_results.size() == 0) begin
          flag_error("result with no request pending");
        end else begin
          want = pending_results.pop_front();
          check_field("estimate", got.estimate, want.estimate);
          check_field("variance", got.variance, want.variance);
          check_field("gain", 32'(got.gain), 32'(want.gain));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgProcessNoise:     reg_q = cfg_data_i;
          CfgMeasurementNoise: reg_r = cfg_data_i;
          CfgInitialVariance:  reg_p0 = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = filter_step(s_axis_tuser, s_axis_tdata);
        if (use_typed) want = typed_result;
        pending_results.push_back(want);
      end
    end
  end

  int unsigned stall_left = 0;
  logic [31:0] stall_pattern = '1;
  logic [4:0]  stall_pos = '0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_pattern = $urandom | 32'h1;
      if ($urandom_range(0, 3) == 0) stall_pattern = '1;
      stall_left = $urandom_range(40, 400);
    end
    stall_left--;
    stall_pos++;
    m_axis_tready <= stall_pattern[stall_pos];
  end

  task automatic send_sample(input logic cmd, input logic [31:0] value);
    int unsigned gap;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_variance();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 32'h000F_FFFF);
    endcase
  endfunction

  initial begin
    int sel;
    logic [31:0] trk, amp;
    plan = '{
      '{RowItem,  CmdRestart, '0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'd6554, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'h8000_0000, 1'b0, '0, '0, '0},
      '{RowItem,  CmdRestart, '0, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'd6554, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdMeasure, '0, 32'h0000_0000, 1'b0, '0, '0, '0},
      '{RowItem,  CmdMeasure, '0, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdMeasure, '0, 32'h0001_0000, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgProcessNoise,     32'd0, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgMeasurementNoise, 32'd0, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgInitialVariance,  32'd0, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgNoSuchReg, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdRestart, '0, 32'd5,         1'b1, 32'd5, 32'd0, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'd100,       1'b1, 32'd5, 32'd0, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'hFFFF_FF9C, 1'b1, 32'd5, 32'd0, 17'd0},
      '{RowWrite, CmdMeasure, CfgInitialVariance, 32'h0001_0000, 1'b0, '0, '0, '0},
      '{RowItem,  CmdRestart, '0, 32'd0,         1'b1, 32'd0, 32'h0001_0000, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'h0001_2345, 1'b1, 32'h0001_2345, 32'd0, OneQ16},
      '{RowItem,  CmdMeasure, '0, 32'h8000_0000, 1'b1, 32'h0001_2345, 32'd0, 17'd0},
      '{RowWrite, CmdMeasure, CfgProcessNoise,     32'hFFFF_FFFF, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgMeasurementNoise, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
      '{RowWrite, CmdMeasure, CfgInitialVariance,  32'hFFFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdRestart, '0, 32'd0,         1'b1, 32'd0, 32'hFFFF_FFFF, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdMeasure, '0, 32'h8000_0000, 1'b0, '0, '0, '0},
      '{RowItem,  CmdMeasure, '0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
      '{RowItem,  CmdRestart, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0},
      '{RowItem,  CmdMeasure, '0, 32'h1234_5678, 1'b0, '0, '0, '0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        if (s_axis_tvalid || pending_results.size() != 0) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        typed_result = '{plan[i].estimate, plan[i].variance, plan[i].gain};
        use_typed = plan[i].typed;
        send_sample(plan[i].cmd, plan[i].data);
        use_typed = 1'b0;
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      write_reg(CfgProcessNoise, pick_variance());
      write_reg(CfgMeasurementNoise, pick_variance());
      write_reg(CfgInitialVariance, pick_variance());
      if ($urandom_range(0, 3) == 0) write_reg(CfgNoSuchReg, $urandom);
      trk = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      amp = 32'd1 << $urandom_range(4, 20);
      send_sample(CmdRestart, trk);
      for (int n = 0; n < 124; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
          send_sample(CmdRestart, $urandom_range(0, 1) ? trk : $urandom);
        end else if (sel < 10) begin
          send_sample(CmdMeasure, $urandom);
        end else if (sel < 13) begin
          send_sample(CmdMeasure, sel[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
        end else begin
          trk = trk + $urandom_range(0, 64) - 32'd32;
          send_sample(CmdMeasure, trk + $urandom_range(0, 2 * amp) - amp);
        end
      end
    end

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0)
      $display("PASS scalar_kalman_filter");
    else
      $display("FAIL scalar_kalman_filter");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL scalar_kalman_filter");
    $finish;
  end

endmodule
